// File: hdl/scv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the strided 1D convolution layer.
package scv_pkg;

   localparam int CFG_W      = 5;
   localparam int IDX_W      = 4;
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 48;
   localparam int POS_W      = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;

   localparam logic [CFG_W-1:0] TAPS_RESET     = 5'd3;
   localparam logic [CFG_W-1:0] CHANNELS_RESET = 5'd1;
   localparam logic [CFG_W-1:0] KERNELS_RESET  = 5'd1;
   localparam logic [CFG_W-1:0] STRIDE_RESET   = 5'd1;

   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      CSR_TAPS     = 2'd0,
      CSR_CHANNELS = 2'd1,
      CSR_KERNELS  = 2'd2,
      CSR_STRIDE   = 2'd3
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_MOD   = 6'b000100,
      ST_MAC   = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

endpackage

// File: hdl/scv_rem.sv
`timescale 1ns / 1ps
// Bit-serial remainder of a window start position by the stride.
module scv_rem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [scv_pkg::POS_W-1:0]      dividend,
   input  logic [scv_pkg::CFG_W-1:0]      divisor,
   output logic                           done,
   output logic [scv_pkg::CFG_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(scv_pkg::POS_W);

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [scv_pkg::POS_W-1:0]   num_ff, num_in;
   logic [scv_pkg::CFG_W-1:0]   div_ff, div_in;
   logic [scv_pkg::CFG_W-1:0]   rem_ff, rem_in;
   logic [scv_pkg::CFG_W:0]     trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[scv_pkg::POS_W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(scv_pkg::POS_W - 1);
         num_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         num_in = {num_ff[scv_pkg::POS_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = scv_pkg::CFG_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = scv_pkg::CFG_W'(trial);
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < div_ff)
      else $error("remainder not below divisor");

   a_no_restart_while_busy : assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("remainder unit restarted while busy");

   a_done_after_run : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("done without a running division");

endmodule

// File: hdl/strided_conv1d_layer.sv
`timescale 1ns / 1ps
// Strided multichannel 1D convolution: window and weight memories, one MAC.
//
//  port group   dir  beat contents
//  req_*        in   tuser kind, tlast end of sequence, tdata weight index/value or sample
//  rsp_*        out  tdata position/kernel/sum, tlast last kernel of the position
//  csr_*        in   write enable, register index, 5-bit value
//
//  Weight beats and samples that close no window leave the sequencer idle.
//  A sample that closes a position with a full window starts the serial stride
//  remainder, then, when the stride hits, runs each kernel over taps x channels:
//  one multiply-add per cycle through the window/weight memories.
//  After reset the window memory is zeroed, with req_tready low.
//  rsp_tready low holds the next kernel result; the sequencer waits for it.
module strided_conv1d_layer #(
   parameter int MAX_TAPS     = 16,
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_KERNELS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [3:0] weight_kernel, [7:4] weight_tap, [11:8] weight_channel,
   // [27:12] weight_value, [43:28] sample_value, [47:44] zero
   input  logic [scv_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] kind
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] out_position, [19:16] out_kernel, [67:20] out_value, [71:68] zero
   output logic [scv_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [scv_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int WIN_DEPTH = MAX_TAPS * MAX_CHANNELS;
   localparam int WT_DEPTH  = MAX_KERNELS * MAX_TAPS * MAX_CHANNELS;
   localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int WT_AW     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
   localparam int SW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int KW        = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;

   // request fields
   logic [scv_pkg::IDX_W-1:0]           w_kernel, w_tap, w_chan;
   logic signed [scv_pkg::SAMPLE_W-1:0] w_value, s_value;
   assign w_kernel = req_tdata[3:0];
   assign w_tap    = req_tdata[7:4];
   assign w_chan   = req_tdata[11:8];
   assign w_value  = req_tdata[27:12];
   assign s_value  = req_tdata[43:28];

   // configuration
   logic [scv_pkg::CFG_W-1:0] taps_cfg_ff, chans_cfg_ff, kers_cfg_ff, stride_cfg_ff;
   logic [scv_pkg::CFG_W-1:0] taps_eff, chans_eff, kers_eff, stride_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_cfg_ff   <= scv_pkg::TAPS_RESET;
         chans_cfg_ff  <= scv_pkg::CHANNELS_RESET;
         kers_cfg_ff   <= scv_pkg::KERNELS_RESET;
         stride_cfg_ff <= scv_pkg::STRIDE_RESET;
      end else if (csr_we) begin
         case (scv_pkg::csr_index_type'(csr_index))
            scv_pkg::CSR_TAPS:     taps_cfg_ff   <= csr_wdata;
            scv_pkg::CSR_CHANNELS: chans_cfg_ff  <= csr_wdata;
            scv_pkg::CSR_KERNELS:  kers_cfg_ff   <= csr_wdata;
            scv_pkg::CSR_STRIDE:   stride_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (taps_cfg_ff == '0)                  taps_eff = 5'd1;
      else if (int'(taps_cfg_ff) > MAX_TAPS)  taps_eff = 5'(MAX_TAPS);
      else                                    taps_eff = taps_cfg_ff;
      if (chans_cfg_ff == '0)                     chans_eff = 5'd1;
      else if (int'(chans_cfg_ff) > MAX_CHANNELS) chans_eff = 5'(MAX_CHANNELS);
      else                                        chans_eff = chans_cfg_ff;
      if (kers_cfg_ff == '0)                    kers_eff = 5'd1;
      else if (int'(kers_cfg_ff) > MAX_KERNELS) kers_eff = 5'(MAX_KERNELS);
      else                                      kers_eff = kers_cfg_ff;
      stride_eff = (stride_cfg_ff == '0) ? 5'd1 : stride_cfg_ff;
   end

   // sequencer state
   scv_pkg::state_type        state_ff, state_in;
   logic [WIN_AW-1:0]         clr_ff, clr_in;
   logic [CW-1:0]             ch_ff, ch_in;
   logic [scv_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [SW-1:0]             slot_ff, slot_in;
   logic [scv_pkg::POS_W-1:0] oc_ff, oc_in;
   logic [KW-1:0]             k_ff, k_in;
   logic [SW-1:0]             t_ff, t_in;
   logic [CW-1:0]             c_ff, c_in;
   logic [SW-1:0]             ws_ff, ws_in;
   logic [SW-1:0]             slot_start_ff, slot_start_in;
   logic [scv_pkg::POS_W-1:0] out_pos_ff, out_pos_in;
   logic                      eos_pend_ff, eos_pend_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [scv_pkg::POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [scv_pkg::IDX_W-1:0]        rsp_kernel_ff, rsp_kernel_in;
   logic signed [scv_pkg::ACC_W-1:0] rsp_value_ff, rsp_value_in;
   logic                             rsp_last_ff, rsp_last_in;

   // datapath
   logic signed [scv_pkg::SAMPLE_W-1:0] win_mem [WIN_DEPTH];
   logic signed [scv_pkg::SAMPLE_W-1:0] wt_mem [WT_DEPTH];
   logic signed [scv_pkg::SAMPLE_W-1:0] win_rd_ff, wt_rd_ff;
   logic signed [scv_pkg::PROD_W-1:0]   prod_ff;
   logic signed [scv_pkg::ACC_W-1:0]    acc_ff;
   scv_pkg::tag_type                    iss_tag, s1_ff, s2_ff;

   logic                        req_accept, is_sample, pos_done, win_full, launch;
   logic                        c_last, t_last, k_last;
   logic [scv_pkg::POS_W-1:0]   start_pos;
   logic [SW-1:0]               slot_next, slot_first, ws_next;
   logic [7:0]                  slot_sum;
   logic                        win_we, wt_we;
   logic [WIN_AW-1:0]           win_waddr, win_raddr;
   logic [WT_AW-1:0]            wt_waddr, wt_raddr;
   logic signed [scv_pkg::SAMPLE_W-1:0] win_wdata;
   logic                        rem_done;
   logic [scv_pkg::CFG_W-1:0]   rem_value;

   assign req_tready = (state_ff == scv_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign is_sample  = (req_tuser == scv_pkg::KIND_SAMPLE);
   assign pos_done   = (7'(ch_ff) + 7'd1) >= 7'(chans_eff);
   assign win_full   = (17'(pos_ff) + 17'd1) >= 17'(taps_eff);
   assign launch     = req_accept && is_sample && pos_done && win_full;
   assign start_pos  = scv_pkg::POS_W'(17'(pos_ff) + 17'd1 - 17'(taps_eff));

   assign slot_next = (pos_ff == '1) ? '0 :
                      ((int'(slot_ff) + 1 == MAX_TAPS) ? '0 : SW'(int'(slot_ff) + 1));
   always_comb begin
      slot_sum = 8'(slot_ff) + 8'(MAX_TAPS) + 8'd1 - 8'(taps_eff);
      if (slot_sum >= 8'(MAX_TAPS)) slot_sum = slot_sum - 8'(MAX_TAPS);
      slot_first = SW'(slot_sum);
   end
   assign ws_next = (int'(ws_ff) + 1 == MAX_TAPS) ? '0 : SW'(int'(ws_ff) + 1);

   assign c_last = (7'(c_ff) + 7'd1) == 7'(chans_eff);
   assign t_last = (7'(t_ff) + 7'd1) == 7'(taps_eff);
   assign k_last = (7'(k_ff) + 7'd1) == 7'(kers_eff);

   assign iss_tag.valid = (state_ff == scv_pkg::ST_MAC);
   assign iss_tag.first = (c_ff == '0) && (t_ff == '0);
   assign iss_tag.last  = c_last && t_last;

   // memory ports
   assign win_we    = (state_ff == scv_pkg::ST_CLEAR) ||
                      (req_accept && is_sample && (int'(ch_ff) < MAX_CHANNELS));
   assign win_waddr = (state_ff == scv_pkg::ST_CLEAR) ? clr_ff :
                      WIN_AW'(int'(slot_ff) * MAX_CHANNELS + int'(ch_ff));
   assign win_wdata = (state_ff == scv_pkg::ST_CLEAR) ? '0 : s_value;
   assign win_raddr = WIN_AW'(int'(ws_ff) * MAX_CHANNELS + int'(c_ff));

   assign wt_we    = req_accept && !is_sample && (int'(w_kernel) < MAX_KERNELS) &&
                     (int'(w_tap) < MAX_TAPS) && (int'(w_chan) < MAX_CHANNELS);
   assign wt_waddr = WT_AW'((int'(w_kernel) * MAX_TAPS + int'(w_tap)) * MAX_CHANNELS +
                            int'(w_chan));
   assign wt_raddr = WT_AW'((int'(k_ff) * MAX_TAPS + int'(t_ff)) * MAX_CHANNELS +
                            int'(c_ff));

   always_ff @(posedge clock) begin
      if (win_we) win_mem[win_waddr] <= win_wdata;
      win_rd_ff <= win_mem[win_raddr];
   end

   always_ff @(posedge clock) begin
      if (wt_we) wt_mem[wt_waddr] <= w_value;
      wt_rd_ff <= wt_mem[wt_raddr];
   end

   scv_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (launch),
      .dividend  (start_pos),
      .divisor   (stride_eff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ch_in         = ch_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      oc_in         = oc_ff;
      k_in          = k_ff;
      t_in          = t_ff;
      c_in          = c_ff;
      ws_in         = ws_ff;
      slot_start_in = slot_start_ff;
      out_pos_in    = out_pos_ff;
      eos_pend_in   = eos_pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_kernel_in = rsp_kernel_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         scv_pkg::ST_CLEAR: begin
            clr_in = WIN_AW'(int'(clr_ff) + 1);
            if (int'(clr_ff) == WIN_DEPTH - 1) state_in = scv_pkg::ST_IDLE;
         end
         scv_pkg::ST_IDLE: begin
            if (req_accept && is_sample) begin
               if (pos_done) begin
                  ch_in   = '0;
                  pos_in  = pos_ff + 16'd1;
                  slot_in = slot_next;
               end else begin
                  ch_in = CW'(int'(ch_ff) + 1);
               end
               if (launch) begin
                  state_in      = scv_pkg::ST_MOD;
                  slot_start_in = slot_first;
                  out_pos_in    = oc_ff;
                  eos_pend_in   = req_tlast;
               end
               if (req_tlast) begin
                  ch_in   = '0;
                  pos_in  = '0;
                  slot_in = '0;
                  if (!launch) oc_in = '0;
               end
            end
         end
         scv_pkg::ST_MOD: begin
            if (rem_done) begin
               if (rem_value == '0) begin
                  state_in = scv_pkg::ST_MAC;
                  k_in     = '0;
                  t_in     = '0;
                  c_in     = '0;
                  ws_in    = slot_start_ff;
                  oc_in    = oc_ff + 16'd1;
               end else begin
                  state_in = scv_pkg::ST_IDLE;
               end
               if (eos_pend_ff) oc_in = '0;
            end
         end
         scv_pkg::ST_MAC: begin
            if (c_last) begin
               c_in  = '0;
               ws_in = ws_next;
               t_in  = SW'(int'(t_ff) + 1);
               if (t_last) state_in = scv_pkg::ST_DRAIN;
            end else begin
               c_in = CW'(int'(c_ff) + 1);
            end
         end
         scv_pkg::ST_DRAIN: begin
            if (s2_ff.valid && s2_ff.last) state_in = scv_pkg::ST_EMIT;
         end
         scv_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = out_pos_ff;
               rsp_kernel_in = scv_pkg::IDX_W'(k_ff);
               rsp_value_in  = acc_ff;
               rsp_last_in   = k_last;
               if (k_last) begin
                  state_in = scv_pkg::ST_IDLE;
               end else begin
                  state_in = scv_pkg::ST_MAC;
                  k_in     = KW'(int'(k_ff) + 1);
                  t_in     = '0;
                  c_in     = '0;
                  ws_in    = slot_start_ff;
               end
            end
         end
         default: state_in = scv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scv_pkg::ST_CLEAR;
         clr_ff       <= '0;
         ch_ff        <= '0;
         pos_ff       <= '0;
         slot_ff      <= '0;
         oc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         s1_ff        <= '0;
         s2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ch_ff        <= ch_in;
         pos_ff       <= pos_in;
         slot_ff      <= slot_in;
         oc_ff        <= oc_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_ff        <= iss_tag;
         s2_ff        <= s1_ff;
      end
      k_ff          <= k_in;
      t_ff          <= t_in;
      c_ff          <= c_in;
      ws_ff         <= ws_in;
      slot_start_ff <= slot_start_in;
      out_pos_ff    <= out_pos_in;
      eos_pend_ff   <= eos_pend_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_kernel_ff <= rsp_kernel_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      prod_ff       <= win_rd_ff * wt_rd_ff;
      if (s2_ff.valid) begin
         acc_ff <= (s2_ff.first ? '0 : acc_ff) + scv_pkg::ACC_W'(prod_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_value_ff, rsp_kernel_ff, rsp_pos_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_idle_pipe_empty : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!s1_ff.valid && !s2_ff.valid))
      else $error("accepting beats with MAC pipeline busy");

   a_last_mac_to_emit : assert property (@(posedge clock) disable iff (reset)
      (s2_ff.valid && s2_ff.last) |=> (state_ff == scv_pkg::ST_EMIT))
      else $error("final product of a kernel did not lead to emit");

   a_rsp_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == scv_pkg::ST_EMIT))
      else $error("response raised outside emit");

endmodule

// File: test/tb_strided_conv1d_layer.sv
`timescale 1ns / 1ps
// Self-checking testbench for strided_conv1d_layer: stream driver, result checker, predictor.
module tb_strided_conv1d_layer;
   import scv_pkg::*;

   typedef struct {
      logic        kind;
      logic [3:0]  wk;
      logic [3:0]  wt;
      logic [3:0]  wc;
      logic [15:0] wv;
      logic [15:0] sv;
      logic        eos;
   } conv_beat_t;

   typedef struct packed {
      logic [15:0] position;
      logic [3:0]  kernel;
      logic [47:0] total;
      logic        closes_run;
   } conv_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [3:0] weight_kernel, [7:4] weight_tap, [11:8] weight_channel,
   // [27:12] weight_value, [43:28] sample_value, [47:44] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [0] kind
   logic                  req_tuser = KIND_WEIGHT;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] out_position, [19:16] out_kernel, [67:20] out_value, [71:68] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_TAPS;
   logic [CFG_W-1:0]      csr_wdata = '0;

   strided_conv1d_layer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[strided_conv1d_layer] ERROR");
      $finish;
   end

   // predictor state
   logic [4:0]         reg_taps   = TAPS_RESET;
   logic [4:0]         reg_chans  = CHANNELS_RESET;
   logic [4:0]         reg_kers   = KERNELS_RESET;
   logic [4:0]         reg_stride = STRIDE_RESET;
   logic signed [15:0] window_mem [256];
   logic signed [15:0] weight_mem [4096];
   int unsigned        chan_cnt = 0;
   logic [15:0]        pos_cnt = '0;
   logic [15:0]        out_cnt = '0;

   conv_beat_t   pending_beats [$];
   conv_result_t expected_sums [$];
   conv_beat_t   offered;
   bit           weight_planned [4096];
   int           queued_samples = 0;
   int           error_count = 0;
   bit           gaps_on = 1'b1;
   bit           stall_wanted = 1'b0;
   bit           stall_done = 1'b0;
   int           stall_left = 0;

   function automatic int unsigned eff(logic [4:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   task automatic predict_beat(input conv_beat_t b);
      int unsigned        taps, chans, kers, hop, first, ws;
      logic signed [47:0] acc;
      logic signed [31:0] prod;
      conv_result_t       r;
      taps  = eff(reg_taps, 16);
      chans = eff(reg_chans, 16);
      kers  = eff(reg_kers, 16);
      hop   = eff(reg_stride, 31);
      if (b.kind == KIND_WEIGHT) begin
         weight_mem[{b.wk, b.wt, b.wc}] = b.wv;
         return;
      end
      if (chan_cnt < 16) window_mem[pos_cnt[3:0] * 16 + chan_cnt] = b.sv;
      if (chan_cnt + 1 >= chans) begin
         if (pos_cnt + 1 >= taps) begin
            first = pos_cnt + 1 - taps;
            if (first % hop == 0) begin
               for (int k = 0; k < kers; k++) begin
                  acc = '0;
                  for (int t = 0; t < taps; t++) begin
                     ws = (first + t) % 16;
                     for (int c = 0; c < chans; c++) begin
                        prod = window_mem[ws * 16 + c] * weight_mem[k * 256 + t * 16 + c];
                        acc += prod;
                     end
                  end
                  r.position   = out_cnt;
                  r.kernel     = k[3:0];
                  r.total      = acc;
                  r.closes_run = (k + 1 == kers);
                  expected_sums.push_back(r);
               end
               out_cnt++;
            end
         end
         chan_cnt = 0;
         pos_cnt++;
      end else begin
         chan_cnt++;
      end
      if (b.eos) begin
         chan_cnt = 0;
         pos_cnt  = '0;
         out_cnt  = '0;
      end
   endtask

   // input side
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_beat(offered);
         if (!req_tvalid || req_tready) begin
            if (pending_beats.size() != 0 && !(gaps_on && $urandom_range(99) < 29)) begin
               offered = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, offered.sv, offered.wv, offered.wc, offered.wt, offered.wk};
               req_tuser  <= offered.kind;
               req_tlast  <= offered.eos;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side backpressure, with one long hold-off
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_wanted && !stall_done) begin
         stall_done <= 1'b1;
         stall_left <= 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(gaps_on && $urandom_range(99) < 29);
      end
   end

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin : result_check
      conv_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.position   = rsp_tdata[15:0];
         got.kernel     = rsp_tdata[19:16];
         got.total      = rsp_tdata[67:20];
         got.closes_run = rsp_tlast;
         if (expected_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected beat pos %0d kernel %0d",
                                      got.position, got.kernel));
         end else begin
            want = expected_sums.pop_front();
            if (got.position !== want.position)
               report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
            if (got.kernel !== want.kernel)
               report_mismatch($sformatf("kernel %0d, want %0d", got.kernel, want.kernel));
            if (got.total !== want.total)
               report_mismatch($sformatf("sum %0d, want %0d (pos %0d kernel %0d)",
                                         $signed(got.total), $signed(want.total),
                                         want.position, want.kernel));
            if (got.closes_run !== want.closes_run)
               report_mismatch($sformatf("tlast %0b, want %0b (pos %0d kernel %0d)",
                                         got.closes_run, want.closes_run,
                                         want.position, want.kernel));
         end
      end
   end

   // stimulus helpers
   function automatic logic [15:0] rand_word();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic conv_beat_t sample_beat(logic [15:0] v, logic eos);
      conv_beat_t b;
      b.kind = KIND_SAMPLE;
      b.wk   = 4'($urandom);
      b.wt   = 4'($urandom);
      b.wc   = 4'($urandom);
      b.wv   = 16'($urandom);
      b.sv   = v;
      b.eos  = eos;
      return b;
   endfunction

   task automatic plan_weight(int k, int t, int c, logic [15:0] v);
      conv_beat_t b;
      b.kind = KIND_WEIGHT;
      b.wk   = k[3:0];
      b.wt   = t[3:0];
      b.wc   = c[3:0];
      b.wv   = v;
      b.sv   = 16'($urandom);
      b.eos  = ($urandom_range(7) == 0);
      weight_planned[k * 256 + t * 16 + c] = 1'b1;
      pending_beats.push_back(b);
   endtask

   task automatic load_weights(int kers, int taps, int chans);
      for (int k = 0; k < kers; k++)
         for (int t = 0; t < taps; t++)
            for (int c = 0; c < chans; c++)
               if (!weight_planned[k * 256 + t * 16 + c]) plan_weight(k, t, c, rand_word());
   endtask

   task automatic push_sample(logic [15:0] v, logic eos);
      pending_beats.push_back(sample_beat(v, eos));
      queued_samples++;
   endtask

   task automatic queue_run(int positions, int chans, bit close);
      for (int p = 0; p < positions; p++)
         for (int c = 0; c < chans; c++)
            push_sample(rand_word(), close && p == positions - 1 && c == chans - 1);
   endtask

   // end flag inside a position (at its end when there is only one channel)
   task automatic queue_broken_tail(int chans);
      int n;
      n = (chans > 1) ? $urandom_range(1, chans - 1) : 1;
      for (int c = 0; c < n; c++) push_sample(rand_word(), c == n - 1);
   endtask

   task automatic settle();
      while (pending_beats.size() != 0 || req_tvalid || expected_sums.size() != 0)
         @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [4:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_TAPS:     reg_taps   = val;
         CSR_CHANNELS: reg_chans  = val;
         CSR_KERNELS:  reg_kers   = val;
         CSR_STRIDE:   reg_stride = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic [4:0] taps, logic [4:0] chans, logic [4:0] kers,
                            logic [4:0] hop);
      settle();
      write_csr(CSR_TAPS, taps);
      write_csr(CSR_CHANNELS, chans);
      write_csr(CSR_KERNELS, kers);
      write_csr(CSR_STRIDE, hop);
      load_weights(eff(kers, 16), eff(taps, 16), eff(chans, 16));
   endtask

   task automatic random_phase(logic [4:0] taps, logic [4:0] chans, logic [4:0] kers,
                               logic [4:0] hop, bit quiet, bit hold);
      int nt, nc, nk, target, pick;
      configure(taps, chans, kers, hop);
      nt = eff(taps, 16);
      nc = eff(chans, 16);
      nk = eff(kers, 16);
      gaps_on = !quiet;
      if (hold) stall_wanted = 1'b1;
      target = queued_samples + 40;
      while (queued_samples < target) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            queue_run(nt + $urandom_range(0, 6), nc, 1'b1);
         end else if (pick < 82 && nt > 1) begin
            queue_run($urandom_range(1, nt - 1), nc, 1'b1);
         end else if (pick < 92) begin
            queue_run($urandom_range(0, nt + 2), nc, 1'b0);
            queue_broken_tail(nc);
         end else begin
            plan_weight($urandom_range(15), $urandom_range(15), $urandom_range(15), rand_word());
            plan_weight($urandom_range(nk - 1), $urandom_range(nt - 1), $urandom_range(nc - 1),
                        rand_word());
         end
      end
   endtask

   // {taps, channels, kernels, stride}; raw values, zero and above-max included
   function automatic logic [19:0] fixed_setting(int n);
      case (n)
         0: return {5'd16, 5'd1,  5'd1,  5'd1};
         1: return {5'd1,  5'd16, 5'd1,  5'd1};
         2: return {5'd1,  5'd1,  5'd16, 5'd1};
         3: return {5'd2,  5'd1,  5'd1,  5'd31};
         4: return {5'd31, 5'd2,  5'd1,  5'd16};
         5: return {5'd0,  5'd0,  5'd0,  5'd0};
         6: return {5'd3,  5'd31, 5'd1,  5'd2};
         default: return {5'd3, 5'd2, 5'd31, 5'd1};
      endcase
   endfunction

   initial begin : stimulus
      int          phase, goal;
      logic [19:0] cfg;
      logic [4:0]  hop;
      for (int i = 0; i < 256; i++) window_mem[i] = '0;
      for (int i = 0; i < 4096; i++) begin
         weight_mem[i]     = '0;
         weight_planned[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset setting: three taps, one channel, one kernel, stride one
      plan_weight(0, 0, 0, 16'h8000);
      plan_weight(0, 1, 0, 16'h7fff);
      plan_weight(0, 2, 0, 16'h8000);
      plan_weight(15, 15, 15, 16'h7fff);
      push_sample(16'h8000, 1'b0);
      push_sample(16'h7fff, 1'b0);
      push_sample(16'h8000, 1'b0);
      push_sample(16'h7fff, 1'b0);
      push_sample(16'h0000, 1'b1);
      // too short for a window
      push_sample(16'h1234, 1'b0);
      push_sample(16'h8000, 1'b1);

      // zero taps read as one, stride two, end flag mid-position
      configure(5'd0, 5'd2, 5'd2, 5'd2);
      queue_run(3, 2, 1'b0);
      push_sample(rand_word(), 1'b1);
      queue_run(1, 2, 1'b0);
      // settings change with the sequence still open
      configure(5'd2, 5'd1, 5'd1, 5'd3);
      push_sample(rand_word(), 1'b0);
      push_sample(rand_word(), 1'b1);

      goal  = queued_samples + 410;
      phase = 0;
      while (queued_samples < goal) begin
         if (phase < 8) begin
            cfg = fixed_setting(phase);
            random_phase(cfg[19:15], cfg[14:10], cfg[9:5], cfg[4:0], phase == 0, phase == 2);
         end else begin
            hop = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 6));
            random_phase(5'($urandom_range(1, 5)), 5'($urandom_range(1, 4)),
                         5'($urandom_range(1, 4)), hop, 1'b0, 1'b0);
         end
         phase++;
      end
      settle();

      if (error_count == 0) begin
         $display("[strided_conv1d_layer] OK");
      end else begin
         $display("[strided_conv1d_layer] ERROR");
      end
      $finish;
   end

endmodule
